// ===== design/base64_stream_decoder_defines.svh =====
// Assertion macros used by the base64 stream decoder output queue.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64D_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// Next-cycle implication, checked outside reset.
`define B64D_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

// ===== design/b64d_pkg.sv =====
// Types, constants and the character table of the base64 stream decoder.
`default_nettype none
package b64d_pkg;

  // Output queue depth; a quartet pushes up to three items at once.
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned GroupMax   = 3;

  // Character classes.
  typedef enum logic [1:0] {
    KIND_SEXTET,
    KIND_PAD,
    KIND_SKIP
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [5:0] value;
  } char_class_t;

  // One decoded output item.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       stop;
  } out_item_t;

  // Items produced by one input character (count of 0 to 3).
  typedef struct packed {
    logic [1:0]                   count;
    out_item_t [GroupMax-1:0]     items;
  } group_t;

  // Both alphabets: '+'/'-' give 62, '/'/'_' give 63, '=' is pad.
  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.kind  = KIND_SKIP;
    r.value = 6'd0;
    if (c inside {[8'h41:8'h5a]}) begin
      r.kind  = KIND_SEXTET;
      r.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7a]}) begin
      r.kind  = KIND_SEXTET;
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.kind  = KIND_SEXTET;
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c inside {8'h2b, 8'h2d}) begin
      r.kind  = KIND_SEXTET;
      r.value = 6'd62;
    end else if (c inside {8'h2f, 8'h5f}) begin
      r.kind  = KIND_SEXTET;
      r.value = 6'd63;
    end else if (c == 8'h3d) begin
      r.kind  = KIND_PAD;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/b64d_decode.sv =====
// Character classification and quartet assembly for the base64 decoder.
`default_nettype none
module b64d_decode
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire logic [7:0] item_char,
  input  wire logic       item_eom,
  input  wire logic       advance,
  output group_t          group
);

  logic [2:0][5:0] sextet_store;
  logic            third_is_pad;
  logic [1:0]      quartet_position;
  logic            halted;

  char_class_t cls;
  logic        active;
  logic        fourth_pad;
  logic [5:0]  s3;
  logic [7:0]  b0, b1, b2;
  logic [5:0]  store_val;

  // Classify and decide whether the character takes part
  always_comb begin
    cls    = classify(item_char);
    active = item_valid && !halted && !item_char[7] && (cls.kind != KIND_SKIP);
  end

  // Byte assembly for a completed quartet
  always_comb begin
    fourth_pad = (cls.kind == KIND_PAD);
    s3 = fourth_pad ? 6'd0 : cls.value;
    b0 = {sextet_store[0], sextet_store[1][5:4]};
    b1 = {sextet_store[1][3:0], sextet_store[2][5:2]};
    b2 = {sextet_store[2][1:0], s3};
  end

  // Value stored for places one to three; a pad in place one or two counts as 63, in place three as 0
  always_comb begin
    if (cls.kind == KIND_PAD) begin
      store_val = (quartet_position == 2'd2) ? 6'd0 : 6'd63;
    end else begin
      store_val = cls.value;
    end
  end

  // Result group
  always_comb begin
    group = '0;
    group.items[0].data = b0;
    group.items[1].data = b1;
    group.items[2].data = b2;
    for (int i = 0; i < GroupMax; i++) begin
      group.items[i].stop = fourth_pad;
    end
    if (active && quartet_position == 2'd3) begin
      if (third_is_pad) begin
        group.count = 2'd1;
        group.items[0].last = 1'b1;
      end else if (fourth_pad) begin
        group.count = 2'd2;
        group.items[1].last = 1'b1;
      end else begin
        group.count = 2'd3;
        group.items[2].last = 1'b1;
      end
    end
  end

  // Sextet store, no reset needed
  always_ff @(posedge clk) begin
    if (advance && active && quartet_position != 2'd3) begin
      sextet_store[quartet_position] <= store_val;
    end
  end

  // Quartet control state
  always_ff @(posedge clk) begin
    if (rst) begin
      third_is_pad     <= 1'b0;
      quartet_position <= 2'd0;
      halted           <= 1'b0;
    end else if (advance) begin
      if (item_eom) begin
        third_is_pad     <= 1'b0;
        quartet_position <= 2'd0;
        halted           <= 1'b0;
      end else if (active) begin
        if (quartet_position == 2'd3) begin
          quartet_position <= 2'd0;
          third_is_pad     <= 1'b0;
          if (fourth_pad) begin
            halted <= 1'b1;
          end
        end else begin
          quartet_position <= quartet_position + 2'd1;
          if (quartet_position == 2'd2) begin
            third_is_pad <= (cls.kind == KIND_PAD);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/b64d_queue.sv =====
// Output queue: takes up to three items per cycle, delivers one per cycle while m_tready is high.
`default_nettype none
module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  group_t          group,
  output logic            room,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output out_item_t       head
);
`include "base64_stream_decoder_defines.svh"

  out_item_t [QueueDepth-1:0] mem;
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic [1:0]        push_count;
  logic              pop;

  // Handshake and occupancy
  always_comb begin
    room       = (count <= CountW'(QueueDepth - GroupMax));
    push_count = push ? group.count : 2'd0;
    m_tvalid   = (count != '0);
    pop        = m_tvalid && m_tready;
    head       = mem[rd_ptr];
    count_next = count + CountW'(push_count) - CountW'(pop);
  end

  // Storage writes
  always_ff @(posedge clk) begin
    for (int i = 0; i < GroupMax; i++) begin
      if (2'(i) < push_count) begin
        mem[wr_ptr + PtrW'(i)] <= group.items[i];
      end
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  `B64D_ASSERT_IMPL(a_no_overflow, clk, rst, push_count != 2'd0, room)
  `B64D_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CountW'(QueueDepth))
  `B64D_ASSERT_NEXT(a_pop_only, clk, rst, push_count == 2'd0 && pop,
                    count == $past(count) - CountW'(1))
  `B64D_ASSERT_NEXT(a_idle_hold, clk, rst, push_count == 2'd0 && !pop, $stable(count))

endmodule
`default_nettype wire

// ===== design/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder (both alphabets).
//
// Input channel s_*: one character per item in s_tdata, s_tlast marks the
// last character of a message. Output channel m_*: one decoded byte per
// item in m_tdata, m_tlast on the last byte of a quartet, m_tuser[0] set
// on every byte of a quartet that ended with a pad ('=').
// An accepted character is held in an input register while it is
// classified and folded into the current quartet; when the fourth
// character leaves that register, one to three bytes are pushed into an
// 8-entry output queue, and they reach m_* once registered there.
// Throughput: one character per cycle while the queue has room, set by
// the input register and the queue's three-item push; sustained output
// is one byte per cycle while m_tready is high, so a stream of full
// quartets runs at the full character rate.
// s_tready drops when the queue has fewer than three free entries and a
// character is waiting; a stalled receiver thus back-pressures the input
// after the queue fills. Reset (rst, synchronous) empties the queue and
// returns the quartet state to the start of a message.
`default_nettype none
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] char_in
  input  wire logic       s_tlast,   // end_of_message
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] data_byte
  output logic            m_tlast,   // last_of_group
  output logic [0:0]      m_tuser    // [0] padding_stop
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eom;
  logic       room;
  logic       advance;
  group_t     group;
  out_item_t  head;

  // Input register advances when the queue can take a full group
  always_comb begin
    advance  = in_valid && room;
    s_tready = !in_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_eom  <= s_tlast;
    end
  end

  b64d_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item_char  (in_char),
    .item_eom   (in_eom),
    .advance    (advance),
    .group      (group)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (advance),
    .group    (group),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  // Output fields
  always_comb begin
    m_tdata    = head.data;
    m_tlast    = head.last;
    m_tuser[0] = head.stop;
  end

endmodule
`default_nettype wire
